[src/rotate_point_about_centre_macros.svh]
// assertion macros used by the checker of the point rotator
`ifndef ROTATE_POINT_ABOUT_CENTRE_MACROS_SVH
`define ROTATE_POINT_ABOUT_CENTRE_MACROS_SVH

// same-cycle implication, clocked on clk and switched off during reset
`define RPAC_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication with a fixed delay in cycles before the consequent
`define RPAC_ASSERT_DELAYED(label, ante, dly, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

[src/rpac_pkg.sv]
// types, constants and gain helpers for the point rotator
`default_nettype none

package rpac_pkg;

    // field widths
    localparam int COORD_W     = 24;
    localparam int ANGLE_W     = 16;
    localparam int ANGLE_SHIFT = 11;
    localparam int OFFSET_W    = COORD_W + 1;
    localparam int PRESCALE    = 8;

    // phase in units of 2^-24 rad, wide enough for plus or minus pi
    localparam int PHASE_W = ANGLE_W + ANGLE_SHIFT;

    // rotator datapath: scaled offset plus headroom for the cordic growth
    localparam int DP_W = 35;

    // gain in Q.28 and the split multiply that applies it
    localparam int GAIN_W    = 29;
    localparam int GAIN_FRAC = 28;
    localparam int LOW_W     = 17;
    localparam int HIGH_W    = DP_W - LOW_W;
    localparam int PROD_W    = HIGH_W + GAIN_W;
    localparam int SUM_W     = DP_W + GAIN_W + 1;
    localparam int ROUND_POS = 36;
    localparam int SCALED_W  = SUM_W - ROUND_POS;
    localparam int SAT_W     = SCALED_W + 1;

    localparam int PI_UNITS      = 52707179;
    localparam int HALF_PI_UNITS = 26353589;

    localparam logic signed [PHASE_W-1:0] PI_PHASE      = PHASE_W'(PI_UNITS);
    localparam logic signed [PHASE_W-1:0] HALF_PI_PHASE = PHASE_W'(HALF_PI_UNITS);

    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    // arctangent of 2^-i in units of 2^-24 rad, rounded to nearest
    localparam int ATAN_TABLE_SIZE = 24;
    localparam logic [PHASE_W-1:0] ATAN_UNITS [ATAN_TABLE_SIZE] = '{
        27'd13176795, 27'd7778716, 27'd4110060, 27'd2086331,
        27'd1047214,  27'd524117,  27'd262123,  27'd131069,
        27'd65536,    27'd32768,   27'd16384,   27'd8192,
        27'd4096,     27'd2048,    27'd1024,    27'd512,
        27'd256,      27'd128,     27'd64,      27'd32,
        27'd16,       27'd8,       27'd4,       27'd2
    };

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CENTRE_X = 2'd0,
        REG_CENTRE_Y = 2'd1
    } rpac_reg_t;

    // input beat
    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [ANGLE_W-1:0] turn_angle;
        logic                      reverse_turn;
    } rpac_item_t;

    // result beat
    typedef struct packed {
        logic signed [COORD_W-1:0] rotated_x;
        logic signed [COORD_W-1:0] rotated_y;
    } rpac_result_t;

    // product of (1 + 2^-2i) in Q.60, truncated at each step
    function automatic logic [63:0] gain_product(input int stages);
        logic [63:0] prod;
        prod = 64'd1 << 60;
        for (int i = 0; i < ATAN_TABLE_SIZE; i++) begin
            if (i < stages) begin
                prod = prod + (prod >> (2 * i));
            end
        end
        return prod;
    endfunction

    // integer square root, two bits a step
    function automatic logic [63:0] isqrt64(input logic [63:0] val);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] probe;
        rem   = val;
        root  = 64'd0;
        probe = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (rem >= root + probe) begin
                rem  = rem - (root + probe);
                root = (root >> 1) + probe;
            end
            else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

endpackage

`default_nettype wire

[src/rotate_point_about_centre.sv]
// top level of the point rotator: centre offset, pipelined cordic, gain and centre restore
`default_nettype none

// Rotates a point about the configured centre by turn_angle (negated when
// reverse_turn is set, clamped to plus or minus pi). One beat is taken on
// every clock edge with start high and busy low; busy is high only while in
// reset and until its ready register is set after reset, so a new point can
// follow every cycle. Each result appears on result with done high for
// exactly one cycle. Its beat passes stage a (direction, clamp and centre
// offset) and stage b (offset scaling and half-turn fold) for the angle
// reduction, a register per cordic micro-rotation, then the split gain
// multiply, the rounding add and the centre restore and saturation, each
// registered. The receiver cannot stall the pipeline, so results leave in
// order at the input rate. The centre registers take writes on the cfg channel
// (cfg_ready is the inverse of busy) and should only change while no point is in flight.
module rotate_point_about_centre #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   start,
    output logic                                  busy,
    input  rpac_pkg::rpac_item_t                  item,
    input  wire                                   cfg_valid,
    output logic                                  cfg_ready,
    input  wire [rpac_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  wire [rpac_pkg::COORD_W-1:0]           cfg_data,
    output logic                                  done,
    output rpac_pkg::rpac_result_t                result
);

    import rpac_pkg::*;

    localparam int STAGES = (CORDIC_STAGES > ATAN_TABLE_SIZE) ? ATAN_TABLE_SIZE
                                                             : CORDIC_STAGES;
    localparam logic [63:0] GAIN_ROOT = isqrt64(gain_product(STAGES));
    localparam logic [63:0] GAIN_Q    = ((64'd1 << (2 * GAIN_FRAC + 2)) + (GAIN_ROOT >> 1))
                                        / GAIN_ROOT;
    localparam logic signed [GAIN_W-1:0] GAIN = $signed(GAIN_W'(GAIN_Q));
    localparam logic signed [SUM_W-1:0]  ROUND_BIAS = SUM_W'(1) <<< (ROUND_POS - 1);

    // ready after reset, the pipeline never stalls
    logic ready_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg <= 1'b0;
        end
        else
        begin
            ready_reg <= 1'b1;
        end
    end

    assign busy      = !ready_reg;
    assign cfg_ready = ready_reg;

    // centre registers
    logic signed [COORD_W-1:0] centre_x_reg, centre_x_next;
    logic signed [COORD_W-1:0] centre_y_reg, centre_y_next;

    always_comb
    begin
        centre_x_next = centre_x_reg;
        centre_y_next = centre_y_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_CENTRE_X: centre_x_next = $signed(cfg_data);
                REG_CENTRE_Y: centre_y_next = $signed(cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            centre_x_reg <= '0;
            centre_y_reg <= '0;
        end
        else
        begin
            centre_x_reg <= centre_x_next;
            centre_y_reg <= centre_y_next;
        end
    end

    // stage a: direction, clamp to plus or minus pi, offset from centre
    logic                       a_valid_reg, a_valid_next;
    logic signed [PHASE_W-1:0]  a_ang_reg, a_ang_next;
    logic signed [OFFSET_W-1:0] a_dx_reg, a_dx_next;
    logic signed [OFFSET_W-1:0] a_dy_reg, a_dy_next;
    logic signed [PHASE_W:0]    a_wide;
    logic signed [PHASE_W:0]    a_dir;

    always_comb
    begin
        a_valid_next = start && ready_reg;
        a_wide = {item.turn_angle[ANGLE_W-1], item.turn_angle, {ANGLE_SHIFT{1'b0}}};
        a_dir  = item.reverse_turn ? -a_wide : a_wide;
        priority if (a_dir > $signed({1'b0, PI_PHASE}))
        begin
            a_ang_next = PI_PHASE;
        end
        else if (a_dir < -$signed({1'b0, PI_PHASE}))
        begin
            a_ang_next = -PI_PHASE;
        end
        else
        begin
            a_ang_next = a_dir[PHASE_W-1:0];
        end
        a_dx_next = {item.point_x[COORD_W-1], item.point_x}
                  - {centre_x_reg[COORD_W-1], centre_x_reg};
        a_dy_next = {item.point_y[COORD_W-1], item.point_y}
                  - {centre_y_reg[COORD_W-1], centre_y_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_ang_reg <= a_ang_next;
        a_dx_reg  <= a_dx_next;
        a_dy_reg  <= a_dy_next;
    end

    // stage b: scale the offset, fold angles beyond half pi by a half turn
    logic signed [DP_W-1:0]    cx_reg [STAGES+1];
    logic signed [DP_W-1:0]    cy_reg [STAGES+1];
    logic signed [PHASE_W-1:0] cz_reg [STAGES];
    logic                      cv_reg [STAGES+1];
    logic signed [DP_W-1:0]    b_x_next, b_y_next, b_x_scaled, b_y_scaled;
    logic signed [PHASE_W-1:0] b_z_next;

    always_comb
    begin
        b_x_scaled = {{(DP_W-OFFSET_W-PRESCALE){a_dx_reg[OFFSET_W-1]}}, a_dx_reg,
                      {PRESCALE{1'b0}}};
        b_y_scaled = {{(DP_W-OFFSET_W-PRESCALE){a_dy_reg[OFFSET_W-1]}}, a_dy_reg,
                      {PRESCALE{1'b0}}};
        priority if (a_ang_reg > HALF_PI_PHASE)
        begin
            b_x_next = -b_x_scaled;
            b_y_next = -b_y_scaled;
            b_z_next = a_ang_reg - PI_PHASE;
        end
        else if (a_ang_reg < -HALF_PI_PHASE)
        begin
            b_x_next = -b_x_scaled;
            b_y_next = -b_y_scaled;
            b_z_next = a_ang_reg + PI_PHASE;
        end
        else
        begin
            b_x_next = b_x_scaled;
            b_y_next = b_y_scaled;
            b_z_next = a_ang_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cv_reg[0] <= 1'b0;
        end
        else
        begin
            cv_reg[0] <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg[0] <= b_x_next;
        cy_reg[0] <= b_y_next;
        cz_reg[0] <= b_z_next;
    end

    // cordic micro-rotations, one register stage each
    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        logic signed [DP_W-1:0] x_next, y_next, xs, ys;
        logic                   turn_down;

        always_comb
        begin
            xs        = cx_reg[i] >>> i;
            ys        = cy_reg[i] >>> i;
            turn_down = cz_reg[i][PHASE_W-1];
            if (!turn_down)
            begin
                x_next = cx_reg[i] - ys;
                y_next = cy_reg[i] + xs;
            end
            else
            begin
                x_next = cx_reg[i] + ys;
                y_next = cy_reg[i] - xs;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cv_reg[i+1] <= 1'b0;
            end
            else
            begin
                cv_reg[i+1] <= cv_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            cx_reg[i+1] <= x_next;
            cy_reg[i+1] <= y_next;
        end

        // residual angle, not needed after the last micro-rotation
        if (i < STAGES - 1)
        begin : g_phase
            logic signed [PHASE_W-1:0] z_next;

            always_comb
            begin
                if (!turn_down)
                begin
                    z_next = cz_reg[i] - $signed(ATAN_UNITS[i]);
                end
                else
                begin
                    z_next = cz_reg[i] + $signed(ATAN_UNITS[i]);
                end
            end

            always_ff @(posedge clk)
            begin
                cz_reg[i+1] <= z_next;
            end
        end
    end

    // gain multiply, split into high and low partial products
    logic                     m_valid_reg;
    logic signed [PROD_W-1:0] m_xh_reg, m_xl_reg, m_yh_reg, m_yl_reg;
    logic signed [PROD_W-1:0] m_xh_next, m_xl_next, m_yh_next, m_yl_next;

    always_comb
    begin
        m_xh_next = PROD_W'($signed(cx_reg[STAGES][DP_W-1:LOW_W])) * PROD_W'(GAIN);
        m_xl_next = PROD_W'($signed({1'b0, cx_reg[STAGES][LOW_W-1:0]})) * PROD_W'(GAIN);
        m_yh_next = PROD_W'($signed(cy_reg[STAGES][DP_W-1:LOW_W])) * PROD_W'(GAIN);
        m_yl_next = PROD_W'($signed({1'b0, cy_reg[STAGES][LOW_W-1:0]})) * PROD_W'(GAIN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= cv_reg[STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        m_xh_reg <= m_xh_next;
        m_xl_reg <= m_xl_next;
        m_yh_reg <= m_yh_next;
        m_yl_reg <= m_yl_next;
    end

    // recombine, round half up and drop the fraction
    logic                       s_valid_reg;
    logic signed [SCALED_W-1:0] s_x_reg, s_y_reg, s_x_next, s_y_next;
    logic signed [SUM_W-1:0]    s_x_sum, s_y_sum;

    always_comb
    begin
        s_x_sum  = (SUM_W'(m_xh_reg) <<< LOW_W) + SUM_W'(m_xl_reg) + ROUND_BIAS;
        s_y_sum  = (SUM_W'(m_yh_reg) <<< LOW_W) + SUM_W'(m_yl_reg) + ROUND_BIAS;
        s_x_next = s_x_sum[SUM_W-1:ROUND_POS];
        s_y_next = s_y_sum[SUM_W-1:ROUND_POS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
        end
        else
        begin
            s_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s_x_reg <= s_x_next;
        s_y_reg <= s_y_next;
    end

    // restore the centre and saturate to the coordinate range
    logic                    done_reg;
    rpac_result_t            result_reg, result_next;
    logic signed [SAT_W-1:0] o_x_sum, o_y_sum;

    always_comb
    begin
        o_x_sum = SAT_W'(s_x_reg) + SAT_W'(centre_x_reg);
        o_y_sum = SAT_W'(s_y_reg) + SAT_W'(centre_y_reg);
        priority if (o_x_sum > SAT_W'(COORD_MAX))
        begin
            result_next.rotated_x = COORD_MAX;
        end
        else if (o_x_sum < SAT_W'(COORD_MIN))
        begin
            result_next.rotated_x = COORD_MIN;
        end
        else
        begin
            result_next.rotated_x = o_x_sum[COORD_W-1:0];
        end
        priority if (o_y_sum > SAT_W'(COORD_MAX))
        begin
            result_next.rotated_y = COORD_MAX;
        end
        else if (o_y_sum < SAT_W'(COORD_MIN))
        begin
            result_next.rotated_y = COORD_MIN;
        end
        else
        begin
            result_next.rotated_y = o_y_sum[COORD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

[src/rpac_checker.sv]
// port-level checker for the point rotator and its bind
`default_nettype none
`include "rotate_point_about_centre_macros.svh"

module rpac_checker #(
    parameter int CORDIC_STAGES = 16
) (
    input wire                               clk,
    input wire                               rst_n,
    input wire                               start,
    input wire                               busy,
    input rpac_pkg::rpac_item_t              item,
    input wire                               cfg_valid,
    input wire                               cfg_ready,
    input wire [rpac_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input wire [rpac_pkg::COORD_W-1:0]       cfg_data,
    input wire                               done,
    input rpac_pkg::rpac_result_t            result
);

    import rpac_pkg::*;

    localparam int STAGES  = (CORDIC_STAGES > ATAN_TABLE_SIZE) ? ATAN_TABLE_SIZE
                                                              : CORDIC_STAGES;
    localparam int LATENCY = STAGES + 5;

    // shadow of the centre registers, tracked from the write channel
    logic signed [COORD_W-1:0] cx_shadow_reg, cx_shadow_next;
    logic signed [COORD_W-1:0] cy_shadow_reg, cy_shadow_next;

    always_comb
    begin
        cx_shadow_next = cx_shadow_reg;
        cy_shadow_next = cy_shadow_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_CENTRE_X: cx_shadow_next = $signed(cfg_data);
                REG_CENTRE_Y: cy_shadow_next = $signed(cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_shadow_reg <= '0;
            cy_shadow_reg <= '0;
        end
        else
        begin
            cx_shadow_reg <= cx_shadow_next;
            cy_shadow_reg <= cy_shadow_next;
        end
    end

    // every beat taken gives a result after the pipeline latency
    `RPAC_ASSERT_DELAYED(a_beat_gives_result, start && !busy, LATENCY, done,
        "accepted beat did not produce a result at the pipeline latency")

    // no result without a beat taken exactly one latency earlier
    `RPAC_ASSERT_IMPLIES(a_result_has_beat, done, $past(start && !busy, LATENCY),
        "result strobe without a matching accepted beat")

    // a point on the centre stays on the centre, whatever the angle
    `RPAC_ASSERT_IMPLIES(a_centre_fixed,
        done && $past(start && !busy && item.point_x == cx_shadow_reg
                      && item.point_y == cy_shadow_reg, LATENCY)
        && $past(cx_shadow_reg, LATENCY) == $past(cx_shadow_reg, 1)
        && $past(cy_shadow_reg, LATENCY) == $past(cy_shadow_reg, 1),
        result.rotated_x == $past(cx_shadow_reg, 1)
        && result.rotated_y == $past(cy_shadow_reg, 1),
        "point at the centre did not come back as the centre")

endmodule

bind rotate_point_about_centre rpac_checker #(
    .CORDIC_STAGES(CORDIC_STAGES)
) u_rpac_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .item     (item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .done     (done),
    .result   (result)
);

`default_nettype wire
